// ===== design/skvt_pkg.sv =====
// Shared constants, codes and types of the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

   // Number of key/value entries the table holds.
   localparam int CAPACITY = 16;

   // Widths of the request and response fields.
   localparam int OP_W        = 2;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_CNT_W = 5;

   // Width of the internal entry counter, able to hold CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         count_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request and run the compare
      logic apply;     // update the table and load the response register
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/skvt_req_if.sv =====
// Request channel of the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none

interface skvt_req_if;
   logic                              valid;
   logic                              ready;
   logic [skvt_pkg::OP_W-1:0]         operation;
   logic signed [skvt_pkg::DATA_W-1:0] key;
   logic signed [skvt_pkg::DATA_W-1:0] value;

   modport source (output valid, output operation, output key, output value, input ready);
   modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== design/skvt_rsp_if.sv =====
// Response channel of the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none

interface skvt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [skvt_pkg::STATUS_W-1:0]        status;
   logic signed [skvt_pkg::DATA_W-1:0]   found_value;
   logic [skvt_pkg::ENTRY_CNT_W-1:0]     entry_count;

   modport source (output valid, output status, output found_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_value, input entry_count,
                   output ready);
endinterface

`default_nettype wire

// ===== design/skvt_ctrl.sv =====
// Controller: sequences compare and apply and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module skvt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output skvt_pkg::cmd_type      cmd
);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_APPLY = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic out_free;
   logic apply;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // The response register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign apply     = (state_ff == S_APPLY) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = accept;
   assign cmd.apply   = apply;

endmodule

`default_nettype wire

// ===== design/skvt_datapath.sv =====
// Datapath: per-entry compare cells, shifting key/value store and response register.
`timescale 1ns / 1ps
`default_nettype none

module skvt_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire skvt_pkg::cmd_type                     cmd,
   input  wire logic [skvt_pkg::OP_W-1:0]             req_operation,
   input  wire logic signed [skvt_pkg::DATA_W-1:0]    req_key,
   input  wire logic signed [skvt_pkg::DATA_W-1:0]    req_value,
   output logic [skvt_pkg::STATUS_W-1:0]              rsp_status,
   output logic signed [skvt_pkg::DATA_W-1:0]         rsp_found_value,
   output logic [skvt_pkg::ENTRY_CNT_W-1:0]           rsp_entry_count
);

   localparam int CAP = skvt_pkg::CAPACITY;

   // Entry cells, kept in ascending signed key order below count_ff.
   skvt_pkg::data_type key_ff   [CAP];
   skvt_pkg::data_type value_ff [CAP];
   skvt_pkg::data_type key_in   [CAP];
   skvt_pkg::data_type value_in [CAP];
   skvt_pkg::count_type count_ff, count_in;

   // Captured request and compare results.
   logic [skvt_pkg::OP_W-1:0] op_ff;
   skvt_pkg::data_type        new_key_ff;
   skvt_pkg::data_type        new_value_ff;
   logic [CAP-1:0]            lt_ff, lt_in;
   logic [CAP-1:0]            eq_ff, eq_in;

   // Response payload.
   logic [skvt_pkg::STATUS_W-1:0] status_ff, status_in;
   skvt_pkg::data_type            found_ff, found_in;

   logic hit, full, do_insert, do_remove, do_overwrite;
   skvt_pkg::data_type hit_value;

   // Compare every live entry against the incoming key.
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         lt_in[i] = (skvt_pkg::CNT_W'(i) < count_ff) && (key_ff[i] < req_key);
         eq_in[i] = (skvt_pkg::CNT_W'(i) < count_ff) && (key_ff[i] == req_key);
      end
   end

   assign hit          = |eq_ff;
   assign full         = (count_ff == skvt_pkg::CNT_W'(CAP));
   assign do_insert    = (op_ff == skvt_pkg::OP_INSERT) && !hit && !full;
   assign do_overwrite = (op_ff == skvt_pkg::OP_INSERT) && hit;
   assign do_remove    = (op_ff == skvt_pkg::OP_REMOVE) && hit;

   // A cell keeps, takes its lower or upper neighbor, the new pair or just the new value.
   for (genvar g = 0; g < CAP; g++) begin : g_cell
      logic take_new;
      logic upper_ok;
      skvt_pkg::data_type lower_key, lower_value, upper_key, upper_value;

      if (g == 0) begin : g_bottom
         assign take_new    = 1'b1;
         assign lower_key   = key_ff[g];
         assign lower_value = value_ff[g];
      end else begin : g_mid
         assign take_new    = lt_ff[g-1];
         assign lower_key   = key_ff[g-1];
         assign lower_value = value_ff[g-1];
      end

      if (g == CAP - 1) begin : g_top
         assign upper_ok    = 1'b0;
         assign upper_key   = key_ff[g];
         assign upper_value = value_ff[g];
      end else begin : g_low
         assign upper_ok    = 1'b1;
         assign upper_key   = key_ff[g+1];
         assign upper_value = value_ff[g+1];
      end

      always_comb begin
         key_in[g]   = key_ff[g];
         value_in[g] = value_ff[g];
         if (do_insert && !lt_ff[g]) begin
            if (take_new) begin
               key_in[g]   = new_key_ff;
               value_in[g] = new_value_ff;
            end else begin
               key_in[g]   = lower_key;
               value_in[g] = lower_value;
            end
         end else if (do_remove && !lt_ff[g] && upper_ok) begin
            key_in[g]   = upper_key;
            value_in[g] = upper_value;
         end else if (do_overwrite && eq_ff[g]) begin
            value_in[g] = new_value_ff;
         end
      end
   end

   // At most one entry matches, so an AND-OR selects its value.
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < CAP; i++) begin
         hit_value = hit_value | (value_ff[i] & {skvt_pkg::DATA_W{eq_ff[i]}});
      end
   end

   always_comb begin
      status_in = skvt_pkg::ST_DONE;
      found_in  = '0;
      count_in  = count_ff;
      case (op_ff)
         skvt_pkg::OP_INSERT: begin
            if (do_insert) begin
               count_in = count_ff + skvt_pkg::CNT_W'(1);
            end else if (!hit) begin
               status_in = skvt_pkg::ST_FULL;
            end
         end
         skvt_pkg::OP_REMOVE: begin
            if (hit) begin
               count_in = count_ff - skvt_pkg::CNT_W'(1);
            end else begin
               status_in = skvt_pkg::ST_MISSING;
            end
         end
         skvt_pkg::OP_LOOKUP: begin
            if (hit) begin
               found_in = hit_value;
            end else begin
               status_in = skvt_pkg::ST_MISSING;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_operation;
         new_key_ff   <= req_key;
         new_value_ff <= req_value;
         lt_ff        <= lt_in;
         eq_ff        <= eq_in;
      end
      if (cmd.apply) begin
         for (int i = 0; i < CAP; i++) begin
            key_ff[i]   <= key_in[i];
            value_ff[i] <= value_in[i];
         end
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;
   // The counter changes only when a new response is loaded, so it matches the held one.
   assign rsp_entry_count = skvt_pkg::ENTRY_CNT_W'(count_ff);

endmodule

`default_nettype wire

// ===== design/sorted_key_value_table_top.sv =====
// Top level of the sorted key/value table.
//
// The block keeps up to CAPACITY key/value pairs sorted by signed key. Each
// request on req_ch carries an operation (insert or overwrite, remove, or
// lookup), a key and a value; it yields exactly one response on rsp_ch with
// a status, the looked-up value (zero unless a lookup hits) and the entry
// count after the request. Both channels use a valid/ready handshake.
// Timing: a request is taken in the idle state; in that same cycle every
// entry cell compares its key with the request key. In the apply state
// that follows, once the response register is free, the cells shift or
// overwrite in parallel and the response register is loaded, and the
// response turns valid; no new request is taken until the apply is done.
// The pace is set by the two-step compare-then-apply sequence of the controller.
// When the receiver stalls, the held response stays valid and stable; one
// further request is still accepted and waits in the apply step until the
// response register drains. Synchronous reset empties the table (entry
// count zero) and drops any pending response; the key and value stores
// themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table_top (
   input  wire logic clock,
   input  wire logic reset,
   skvt_req_if.sink   req_ch,
   skvt_rsp_if.source rsp_ch
);

   skvt_pkg::cmd_type cmd;

   // The controller runs the handshakes and the idle/apply sequence.
   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // The datapath holds the sorted entries and the response payload.
   skvt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_ch.operation),
      .req_key         (req_ch.key),
      .req_value       (req_ch.value),
      .rsp_status      (rsp_ch.status),
      .rsp_found_value (rsp_ch.found_value),
      .rsp_entry_count (rsp_ch.entry_count)
   );

endmodule

`default_nettype wire

// ===== design/skvt_checker.sv =====
// Port-level checks of the sorted key/value table and their binding.
`timescale 1ns / 1ps
`default_nettype none

module skvt_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [skvt_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic signed [skvt_pkg::DATA_W-1:0]  rsp_found_value,
   input wire logic [skvt_pkg::ENTRY_CNT_W-1:0]    rsp_entry_count
);

   // A pending response is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // With the output free at acceptance, the apply step is not held and the response follows.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (!rsp_valid || rsp_ready) |=> ##1 rsp_valid)
      else $error("response late");

   // A response with a failing status returns a zero value.
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != skvt_pkg::ST_DONE) |-> rsp_found_value == '0)
      else $error("value returned with a failing status");

   // A full report means the table is at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == skvt_pkg::ST_FULL)
      |-> rsp_entry_count == skvt_pkg::ENTRY_CNT_W'(skvt_pkg::CAPACITY))
      else $error("full status with room left");

endmodule

bind sorted_key_value_table_top skvt_checker u_skvt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_found_value (rsp_ch.found_value),
   .rsp_entry_count (rsp_ch.entry_count)
);

`default_nettype wire

// ===== bench/tb_sorted_key_value_table_top.sv =====
// Self-checking testbench for the sorted key/value table, with a predictor and random traffic.
`timescale 1ns / 1ps

module tb_sorted_key_value_table_top;

   // Operation code the block does not use; such a request leaves the table alone.
   localparam logic [skvt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // One predicted response, held until the block delivers its response.
   typedef struct {
      logic [skvt_pkg::STATUS_W-1:0]    status;
      skvt_pkg::data_type               found_value;
      logic [skvt_pkg::ENTRY_CNT_W-1:0] entry_count;
   } table_response_type;

   // The scoreboard keeps its own sorted copy of the table. Every accepted
   // request updates that copy and queues the response the block should
   // give. Every accepted response is matched against the oldest entry.
   class sorted_table_scoreboard;
      skvt_pkg::data_type  shadow_keys[skvt_pkg::CAPACITY];
      skvt_pkg::data_type  shadow_values[skvt_pkg::CAPACITY];
      int                  shadow_count;
      table_response_type  pending_responses[$];
      int unsigned         mismatches;

      function new();
         shadow_count = 0;
         mismatches   = 0;
      endfunction

      function int unsigned pending();
         return pending_responses.size();
      endfunction

      // Prints one line per mismatch and keeps the tally.
      task report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
         $display("%0t ns: MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, seen, wanted);
         mismatches++;
      endtask

      // Applies one accepted request to the shadow table and queues the
      // response it must produce.
      function void note_request(logic [skvt_pkg::OP_W-1:0] op, skvt_pkg::data_type k,
                                 skvt_pkg::data_type v);
         int                 slot;
         bit                 hit;
         table_response_type rsp;
         slot = 0;
         while (slot < shadow_count && shadow_keys[slot] < k)
            slot++;
         hit = (slot < shadow_count) && (shadow_keys[slot] == k);
         rsp.status      = skvt_pkg::ST_DONE;
         rsp.found_value = '0;
         case (op)
            skvt_pkg::OP_INSERT: begin
               if (hit) begin
                  shadow_values[slot] = v;
               end else if (shadow_count >= skvt_pkg::CAPACITY) begin
                  rsp.status = skvt_pkg::ST_FULL;
               end else begin
                  for (int j = shadow_count; j > slot; j--) begin
                     shadow_keys[j]   = shadow_keys[j-1];
                     shadow_values[j] = shadow_values[j-1];
                  end
                  shadow_keys[slot]   = k;
                  shadow_values[slot] = v;
                  shadow_count++;
               end
            end
            skvt_pkg::OP_REMOVE: begin
               if (hit) begin
                  for (int j = slot; j + 1 < shadow_count; j++) begin
                     shadow_keys[j]   = shadow_keys[j+1];
                     shadow_values[j] = shadow_values[j+1];
                  end
                  shadow_count--;
               end else begin
                  rsp.status = skvt_pkg::ST_MISSING;
               end
            end
            skvt_pkg::OP_LOOKUP: begin
               if (hit)
                  rsp.found_value = shadow_values[slot];
               else
                  rsp.status = skvt_pkg::ST_MISSING;
            end
            default: begin
               // An unused operation code leaves the table alone.
            end
         endcase
         rsp.entry_count = skvt_pkg::ENTRY_CNT_W'(shadow_count);
         pending_responses.push_back(rsp);
      endfunction

      // Compares one accepted response with the oldest prediction.
      task check_response(logic [skvt_pkg::STATUS_W-1:0] status,
                          skvt_pkg::data_type found_value,
                          logic [skvt_pkg::ENTRY_CNT_W-1:0] entry_count);
         table_response_type want;
         if (pending_responses.size() == 0) begin
            report_mismatch("response with no request outstanding", 32'(status), 32'hffffffff);
            return;
         end
         want = pending_responses.pop_front();
         if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
         if (found_value !== want.found_value)
            report_mismatch("found_value", found_value, want.found_value);
         if (entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(entry_count), 32'(want.entry_count));
      endtask
   endclass

   logic clock;
   logic reset;

   skvt_req_if req_ch ();
   skvt_rsp_if rsp_ch ();

   sorted_key_value_table_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   sorted_table_scoreboard table_sb = new();

   // When set, the matching side runs without idle cycles for a while, so
   // back-to-back traffic is covered as well as random gaps.
   bit req_no_gaps;
   bit rsp_no_stalls;

   // A small pool of keys keeps the hit rate high enough that overwrites,
   // removes of present keys and a full table all come up often.
   skvt_pkg::data_type key_pool[24];

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = ~clock;
   end

   // Every input of the block is known from time zero on.
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = skvt_pkg::OP_INSERT;
      req_ch.key       = '0;
      req_ch.value     = '0;
      rsp_ch.ready     = 1'b0;
   end

   // Offers one request after a random gap and returns at the edge where it
   // is accepted. Valid stays high on return, so a following request with no
   // gap goes out back to back without valid dropping in between.
   task automatic send_request(logic [skvt_pkg::OP_W-1:0] op, skvt_pkg::data_type k,
                               skvt_pkg::data_type v);
      int gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.key       <= k;
      req_ch.value     <= v;
      do
         @(posedge clock);
      while (!req_ch.ready);
      table_sb.note_request(op, k, v);
   endtask

   // Holds the request channel quiet until every predicted response has come.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (table_sb.pending() != 0)
         @(posedge clock);
   endtask

   // Picks an operation whose mix depends on whether the table is being
   // filled or drained; a few requests carry the unused operation code.
   function automatic logic [skvt_pkg::OP_W-1:0] pick_operation(bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return OP_UNUSED;
      if (filling)
         return (roll < 60) ? skvt_pkg::OP_INSERT :
                (roll < 78) ? skvt_pkg::OP_REMOVE : skvt_pkg::OP_LOOKUP;
      return (roll < 25) ? skvt_pkg::OP_INSERT :
             (roll < 72) ? skvt_pkg::OP_REMOVE : skvt_pkg::OP_LOOKUP;
   endfunction

   // Mostly keys from the pool, now and then a fully random one so every
   // key bit sees both values.
   function automatic skvt_pkg::data_type pick_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, 23)];
      return skvt_pkg::data_type'($urandom());
   endfunction

   // Response side: stalls a random number of cycles before each response,
   // then holds ready until one is taken and checked.
   initial begin : response_sink
      int stall;
      @(posedge clock iff !reset);
      forever begin
         stall = rsp_no_stalls ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_ch.valid);
         table_sb.check_response(rsp_ch.status, rsp_ch.found_value, rsp_ch.entry_count);
      end
   end

   // Request side: reset, a directed opening, then random traffic.
   initial begin : request_source
      skvt_pkg::data_type key_min;
      skvt_pkg::data_type key_max;
      bit                 filling;
      key_min = skvt_pkg::data_type'(32'h8000_0000);
      key_max = skvt_pkg::data_type'(32'h7fff_ffff);

      key_pool[0] = key_min;
      key_pool[1] = key_max;
      key_pool[2] = '0;
      key_pool[3] = -1;
      for (int i = 4; i < 24; i++)
         key_pool[i] = skvt_pkg::data_type'($urandom());

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the key extremes around zero, each operation, and
      // the special cases of an absent key, the unused code and a full table.
      send_request(skvt_pkg::OP_INSERT, key_min, key_max);
      send_request(skvt_pkg::OP_INSERT, key_max, key_min);
      send_request(skvt_pkg::OP_INSERT, -1, 32'h5a5a_a5a5);
      send_request(skvt_pkg::OP_INSERT, 0, -1);
      send_request(skvt_pkg::OP_LOOKUP, key_max, 0);
      send_request(skvt_pkg::OP_LOOKUP, key_min, 0);
      send_request(skvt_pkg::OP_LOOKUP, 5, 0);
      send_request(skvt_pkg::OP_INSERT, -1, 32'h1234_5678);
      send_request(skvt_pkg::OP_LOOKUP, -1, -1);
      send_request(skvt_pkg::OP_REMOVE, 0, 0);
      send_request(skvt_pkg::OP_REMOVE, 0, 0);
      send_request(OP_UNUSED, key_max, -1);
      // Fill the remaining places with keys in an interleaved order so the
      // shifts land in the middle of the table, not only at its end.
      for (int i = 1; i <= 13; i++)
         send_request(skvt_pkg::OP_INSERT, (i % 2 == 1) ? i * 1000 : -i * 1000, i);
      // New key into a full table is refused; an existing key still updates.
      send_request(skvt_pkg::OP_INSERT, 77, 77);
      send_request(skvt_pkg::OP_INSERT, 3000, 32'hdead_beef);
      send_request(skvt_pkg::OP_LOOKUP, 3000, 0);

      // The sender holds off until the block has answered everything.
      drain_responses();

      // Random part: alternating fill and drain phases of random length so
      // the table swings between empty and full many times over.
      filling = 1'b0;
      for (int n = 0; n < 1600; n++) begin
         if (n % 100 == 0) begin
            req_no_gaps   = ($urandom_range(0, 3) == 0);
            rsp_no_stalls = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 59) == 0)
            filling = ~filling;
         if (n % 400 == 399)
            drain_responses();
         send_request(pick_operation(filling), pick_key(), skvt_pkg::data_type'($urandom()));
      end

      drain_responses();
      // Wait on a little longer so a stray extra response would still be caught.
      repeat (10) @(posedge clock);
      if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
         $display("tb_sorted_key_value_table_top passed");
      end else begin
         $display("tb_sorted_key_value_table_top failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("tb_sorted_key_value_table_top failed");
      $finish;
   end

endmodule

// ===== sorted_key_value_table_top.f =====
design/skvt_pkg.sv
design/skvt_req_if.sv
design/skvt_rsp_if.sv
design/skvt_ctrl.sv
design/skvt_datapath.sv
design/sorted_key_value_table_top.sv
design/skvt_checker.sv
bench/tb_sorted_key_value_table_top.sv
